>>> rtl/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg: shared types and constants of the FAT16 cluster chain engine
// Opcodes, status codes, link markers and the command/status bundles that
// pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fcc_pkg;

  // Default table depth
  localparam int unsigned TABLE_ENTRIES_DEF = 4096;

  // Field widths
  localparam int unsigned OP_W       = 3;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned RES_W      = 16;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned STEP_W     = 13;  // hop count never exceeds the 13-bit bound
  localparam int unsigned CMP_W      = 17;  // common width for bound compares
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  // Link markers
  localparam logic [VAL_W-1:0] LINK_FREE    = 16'h0000;
  localparam logic [VAL_W-1:0] LINK_END_LOW = 16'hFFF8;
  localparam logic [VAL_W-1:0] LINK_END     = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD       = 3'd0,
    OP_READ       = 3'd1,
    OP_FIND_FREE  = 3'd2,
    OP_APPEND     = 3'd3,
    OP_ALLOC      = 3'd4,
    OP_FREE_CHAIN = 3'd5,
    OP_ITH        = 3'd6,
    OP_COUNT      = 3'd7
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_CORRUPT = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    DP_NOP        = 4'd0,
    DP_LOAD       = 4'd1,   // capture request fields
    DP_WR_ENTRY   = 4'd2,   // table[index] = value
    DP_RD_IDX     = 4'd3,   // start walk at index
    DP_HOP        = 4'd4,   // follow link
    DP_STEP       = 4'd5,   // follow link and count down i
    DP_SCAN_START = 4'd6,   // read entry 0
    DP_SCAN_NEXT  = 4'd7,   // read next entry
    DP_SCAN_HIT   = 4'd8,   // keep free entry, start walk at index
    DP_LINK       = 4'd9,   // table[tail] = fresh
    DP_MARK       = 4'd10,  // table[fresh] = end marker
    DP_FREE       = 4'd11   // clear entry, follow link
  } dp_op_e;

  typedef enum logic [2:0] {
    RES_REG   = 3'd0,
    RES_DATA  = 3'd1,
    RES_PTR   = 3'd2,
    RES_WP    = 3'd3,
    RES_COUNT = 3'd4,
    RES_VAL   = 3'd5
  } res_sel_e;

  typedef struct packed {
    dp_op_e   op;
    logic     fin;
    status_e  fin_status;
    res_sel_e fin_res;
  } fcc_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    idx_oob;
    logic    val_oob;
    logic    data_stop;
    logic    data_zero;
    logic    link_oob;
    logic    step_over;
    logic    scan_last;
    logic    k_zero;
  } fcc_stat_t;

endpackage

`default_nettype wire

>>> rtl/fcc_ctrl.sv
// ----------------------------------------------------------------------------
// fcc_ctrl: request sequencer
// One-hot state machine that steps each request through checks, scans,
// walks and table writes, and owns the input/output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_ctrl (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output                     logic in_ready_o,
  output                     logic out_valid_o,
  input  wire                logic out_ready_i,
  input  wire fcc_pkg::fcc_stat_t stat_i,
  output fcc_pkg::fcc_cmd_t  cmd_o
);
  import fcc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CHECK   = 9'b000000010,
    S_READ    = 9'b000000100,
    S_SCAN    = 9'b000001000,
    S_WALK    = 9'b000010000,
    S_LINK    = 9'b000100000,
    S_MARK    = 9'b001000000,
    S_SCAN_GO = 9'b010000000,
    S_FREE    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // New request only when idle and the result register is free or draining
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // Sequencer
  always_comb begin
    state_d           = state_q;
    cmd_o.op          = DP_NOP;
    cmd_o.fin         = 1'b0;
    cmd_o.fin_status  = ST_OK;
    cmd_o.fin_res     = RES_REG;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.op != OP_FIND_FREE && stat_i.idx_oob) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = ST_RANGE;
          state_d          = S_IDLE;
        end else begin
          case (stat_i.op)
            OP_LOAD: begin
              cmd_o.op  = DP_WR_ENTRY;
              cmd_o.fin = 1'b1;
              state_d   = S_IDLE;
            end
            OP_READ: begin
              cmd_o.op = DP_RD_IDX;
              state_d  = S_READ;
            end
            OP_FIND_FREE: begin
              cmd_o.op = DP_SCAN_START;
              state_d  = S_SCAN;
            end
            OP_APPEND: begin
              if (stat_i.val_oob) begin
                cmd_o.fin        = 1'b1;
                cmd_o.fin_status = ST_RANGE;
                state_d          = S_IDLE;
              end else begin
                cmd_o.op = DP_RD_IDX;
                state_d  = S_WALK;
              end
            end
            OP_ALLOC: begin
              state_d = S_SCAN_GO;
            end
            default: begin
              // free chain, i-th cluster, count
              cmd_o.op = DP_RD_IDX;
              state_d  = S_WALK;
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.fin     = 1'b1;
        cmd_o.fin_res = RES_DATA;
        state_d       = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.data_zero) begin
          if (stat_i.op == OP_FIND_FREE) begin
            cmd_o.fin     = 1'b1;
            cmd_o.fin_res = RES_PTR;
            state_d       = S_IDLE;
          end else begin
            cmd_o.op = DP_SCAN_HIT;
            state_d  = S_WALK;
          end
        end else if (stat_i.scan_last) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = ST_NONE;
          state_d          = S_IDLE;
        end else begin
          cmd_o.op = DP_SCAN_NEXT;
        end
      end
      S_WALK: begin
        if (stat_i.op == OP_ITH) begin
          // i-th cluster: count down before looking at the link
          if (stat_i.k_zero) begin
            cmd_o.fin     = 1'b1;
            cmd_o.fin_res = RES_WP;
            state_d       = S_IDLE;
          end else if (stat_i.data_stop) begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = ST_NONE;
            state_d          = S_IDLE;
          end else if (stat_i.link_oob || stat_i.step_over) begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = ST_CORRUPT;
            state_d          = S_IDLE;
          end else begin
            cmd_o.op = DP_STEP;
          end
        end else if (stat_i.data_stop) begin
          // tail reached
          case (stat_i.op)
            OP_APPEND, OP_ALLOC: begin
              state_d = S_LINK;
            end
            OP_FREE_CHAIN: begin
              cmd_o.op = DP_RD_IDX;
              state_d  = S_FREE;
            end
            OP_COUNT: begin
              cmd_o.fin     = 1'b1;
              cmd_o.fin_res = RES_COUNT;
              state_d       = S_IDLE;
            end
            default: begin
              cmd_o.fin = 1'b1;
              state_d   = S_IDLE;
            end
          endcase
        end else if (stat_i.link_oob || stat_i.step_over) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = ST_CORRUPT;
          state_d          = S_IDLE;
        end else begin
          cmd_o.op = DP_HOP;
        end
      end
      S_LINK: begin
        cmd_o.op = DP_LINK;
        state_d  = S_MARK;
      end
      S_MARK: begin
        cmd_o.op = DP_MARK;
        if (stat_i.op == OP_APPEND) begin
          cmd_o.fin     = 1'b1;
          cmd_o.fin_res = RES_VAL;
          state_d       = S_IDLE;
        end else begin
          state_d = S_SCAN_GO;
        end
      end
      S_SCAN_GO: begin
        // next cluster of an allocate, or done
        if (stat_i.k_zero) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end else begin
          cmd_o.op = DP_SCAN_START;
          state_d  = S_SCAN;
        end
      end
      S_FREE: begin
        cmd_o.op = DP_FREE;
        if (stat_i.data_stop) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    if (cmd_o.fin) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fcc_dpath.sv
// ----------------------------------------------------------------------------
// fcc_dpath: link table and walk datapath
// Holds the link table memory, the entry-count register, walk pointer,
// hop counter, scan pointer and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcc_dpath #(
  parameter int unsigned TABLE_ENTRIES = fcc_pkg::TABLE_ENTRIES_DEF
) (
  input  wire                logic                         clk_i,
  input  wire                logic                         rst_ni,
  input  wire                logic                         cfg_we_i,
  input  wire                logic [fcc_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire                logic [fcc_pkg::IN_DATA_W-1:0] in_data_i,  // index, value
  input  wire                logic [fcc_pkg::OP_W-1:0]      in_user_i,  // opcode
  input  wire fcc_pkg::fcc_cmd_t                            cmd_i,
  output fcc_pkg::fcc_stat_t                                stat_o,
  output                     logic [fcc_pkg::RES_W-1:0]     res_o,
  output                     logic [fcc_pkg::ST_W-1:0]      status_o
);
  import fcc_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam logic [CMP_W-1:0] TableN = CMP_W'(TABLE_ENTRIES);

  // Entry count register and effective bound
  logic [CFG_W-1:0] cfg_q;
  logic [CFG_W-1:0] n_lim;
  logic [CMP_W-1:0] n_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  assign n_lim = (CMP_W'(cfg_q) > TableN) ? CFG_W'(TableN) : cfg_q;
  assign n_ext = CMP_W'(n_lim);

  // Request and walk registers
  opcode_e           op_q, op_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [VAL_W-1:0]  k_q, k_d;
  logic [RES_W-1:0]  res_q, res_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [STEP_W-1:0] sc_q, sc_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     fresh_q, fresh_d;
  logic [RES_W-1:0]  out_res_q, out_res_d;
  logic [ST_W-1:0]   out_st_q, out_st_d;

  // Memory ports
  logic [VAL_W-1:0] link_mem [TABLE_ENTRIES];
  logic [VAL_W-1:0] data_q;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic [AW-1:0]    rd_addr;

  logic data_zero, data_end;
  assign data_zero = (data_q == LINK_FREE);
  assign data_end  = (data_q >= LINK_END_LOW);

  // Status to the sequencer
  assign stat_o.op        = op_q;
  assign stat_o.idx_oob   = CMP_W'(idx_q) >= n_ext;
  assign stat_o.val_oob   = CMP_W'(val_q) >= n_ext;
  // a scan hit only counts inside the active range
  assign stat_o.data_zero = data_zero && (CMP_W'(ptr_q) < n_ext);
  assign stat_o.data_stop = data_zero || data_end;
  assign stat_o.link_oob  = CMP_W'(data_q) >= n_ext;
  assign stat_o.step_over = CMP_W'(sc_q) >= n_ext;  // one more hop would exceed n
  assign stat_o.scan_last = (CMP_W'(ptr_q) + CMP_W'(1)) >= n_ext;
  assign stat_o.k_zero    = (k_q == '0);

  // Register updates and memory port selection
  always_comb begin
    op_d    = op_q;
    idx_d   = idx_q;
    val_d   = val_q;
    k_d     = k_q;
    res_d   = res_q;
    wp_d    = wp_q;
    sc_d    = sc_q;
    ptr_d   = ptr_q;
    fresh_d = fresh_q;
    wr_en   = 1'b0;
    wr_addr = wp_q;
    wr_data = LINK_FREE;
    rd_addr = wp_q;
    case (cmd_i.op)
      DP_LOAD: begin
        op_d  = opcode_e'(in_user_i);
        idx_d = in_data_i[IDX_W-1:0];
        val_d = in_data_i[IDX_W+VAL_W-1:IDX_W];
        k_d   = in_data_i[IDX_W+VAL_W-1:IDX_W];
        res_d = '0;
      end
      DP_WR_ENTRY: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx_q);
        wr_data = val_q;
      end
      DP_RD_IDX: begin
        rd_addr = AW'(idx_q);
        wp_d    = AW'(idx_q);
        sc_d    = '0;
        fresh_d = AW'(val_q);
      end
      DP_HOP: begin
        rd_addr = AW'(data_q);
        wp_d    = AW'(data_q);
        sc_d    = sc_q + 1'b1;
      end
      DP_STEP: begin
        rd_addr = AW'(data_q);
        wp_d    = AW'(data_q);
        sc_d    = sc_q + 1'b1;
        k_d     = k_q - 1'b1;
      end
      DP_SCAN_START: begin
        rd_addr = '0;
        ptr_d   = '0;
      end
      DP_SCAN_NEXT: begin
        rd_addr = ptr_q + 1'b1;
        ptr_d   = ptr_q + 1'b1;
      end
      DP_SCAN_HIT: begin
        fresh_d = ptr_q;
        rd_addr = AW'(idx_q);
        wp_d    = AW'(idx_q);
        sc_d    = '0;
      end
      DP_LINK: begin
        wr_en   = 1'b1;
        wr_addr = wp_q;
        wr_data = VAL_W'(fresh_q);
      end
      DP_MARK: begin
        wr_en   = 1'b1;
        wr_addr = fresh_q;
        wr_data = LINK_END;
        res_d   = RES_W'(fresh_q);
        k_d     = k_q - 1'b1;
      end
      DP_FREE: begin
        // chain is known acyclic here, so the next read never hits wp
        wr_en   = 1'b1;
        wr_addr = wp_q;
        wr_data = LINK_FREE;
        rd_addr = AW'(data_q);
        wp_d    = AW'(data_q);
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_comb begin
    out_res_d = out_res_q;
    out_st_d  = out_st_q;
    if (cmd_i.fin) begin
      out_st_d = cmd_i.fin_status;
      case (cmd_i.fin_res)
        RES_DATA:  out_res_d = data_q;
        RES_PTR:   out_res_d = RES_W'(ptr_q);
        RES_WP:    out_res_d = RES_W'(wp_q);
        RES_COUNT: out_res_d = RES_W'(sc_q) + RES_W'(data_end);
        RES_VAL:   out_res_d = val_q;
        default:   out_res_d = res_q;
      endcase
    end
  end

  // Link table: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    data_q <= link_mem[rd_addr];
  end

  // Walk state carries a defined reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      sc_q <= '0;
    end else begin
      wp_q <= wp_d;
      sc_q <= sc_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    idx_q     <= idx_d;
    val_q     <= val_d;
    k_q       <= k_d;
    res_q     <= res_d;
    ptr_q     <= ptr_d;
    fresh_q   <= fresh_d;
    out_res_q <= out_res_d;
    out_st_q  <= out_st_d;
  end

  assign res_o    = out_res_q;
  assign status_o = out_st_q;

endmodule

`default_nettype wire

>>> rtl/fat16_cluster_chain_engine_core.sv
// ----------------------------------------------------------------------------
// fat16_cluster_chain_engine_core: FAT16 cluster chain engine
// Link table with load/read, free scan, append, allocate, free-chain,
// i-th cluster and count requests, one result per request.
// ----------------------------------------------------------------------------
// Requests are served one at a time. The link table is a single memory with
// one write and one registered read per cycle, and every scan step and chain
// hop takes one read on that port. Append walks to the tail, then links and
// marks the new cluster; free chain walks to the tail, then clears the chain
// from the head. Allocate repeats a scan, a walk from the chain head and two
// table writes for every cluster. A new request is taken only once the engine
// is back in idle and the previous result has been transferred, or is being
// transferred in that cycle. The table has no reset; entries must be loaded
// before they are read or walked.
`default_nettype none

module fat16_cluster_chain_engine_core #(
  parameter int unsigned TABLE_ENTRIES = fcc_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [fcc_pkg::CFG_W-1:0]        cfg_wdata_i,    // entries_in_use
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  input  wire logic [fcc_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // index[11:0], value[27:12]
  input  wire logic [fcc_pkg::OP_W-1:0]         s_axis_tuser,   // opcode[2:0]
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output      logic [fcc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // result_value[15:0]
  output      logic [fcc_pkg::ST_W-1:0]         m_axis_tuser    // status[1:0]
);
  import fcc_pkg::*;

  fcc_cmd_t  cmd;
  fcc_stat_t stat;

  // Sequencer
  fcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Table and walk datapath
  fcc_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (m_axis_tdata),
    .status_o    (m_axis_tuser)
  );

  // A result is only produced into an empty output register
  a_fin_into_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |-> !m_axis_tvalid)
    else $error("result produced while previous result still pending");

  // After an input transfer the previous result has drained
  a_accept_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("output still valid after input transfer");

  // Every finished request shows up on the output
  a_fin_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |=> m_axis_tvalid)
    else $error("finished request did not raise output valid");

  // No new request is fetched while one is being worked
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_LOAD) |=> !s_axis_tready)
    else $error("input ready while a request is in flight");

endmodule

`default_nettype wire

>>> dv/fat16_cluster_chain_engine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fat16_cluster_chain_engine_core_tb: self-checking bench for the chain engine
// Drives link table requests over the slave stream and checks every result
// on the master stream against an in-bench link table model or a typed-in
// probe answer. A short probe table opens the run; random traffic then runs
// under several entries_in_use settings, mostly with random stalls on both sides.
// ----------------------------------------------------------------------------

module fat16_cluster_chain_engine_core_tb;
  import fcc_pkg::*;

  localparam int unsigned DEPTH = TABLE_ENTRIES_DEF;

  // Expected answer for one request
  typedef struct packed {
    logic [RES_W-1:0] value;
    status_e          status;
  } answer_t;

  // One directed probe; known marks rows whose answer is typed in here
  typedef struct packed {
    opcode_e          op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic             known;
    logic [RES_W-1:0] res;
    status_e          st;
  } probe_t;

  localparam probe_t PROBES [26] = '{
    '{OP_LOAD,       12'd4095, 16'hFFFF, 1'b1, 16'hFFFF & 16'h0, ST_OK},
    '{OP_READ,       12'd4095, 16'h0000, 1'b1, 16'hFFFF, ST_OK},
    '{OP_LOAD,       12'd0,    16'hFFF8, 1'b1, 16'h0000, ST_OK},
    '{OP_LOAD,       12'd1,    16'h0000, 1'b1, 16'h0000, ST_OK},
    '{OP_LOAD,       12'd2,    16'h0000, 1'b1, 16'h0000, ST_OK},
    '{OP_FIND_FREE,  12'd0,    16'h0000, 1'b0, 16'h0000, ST_OK},
    '{OP_ALLOC,      12'd0,    16'h0000, 1'b1, 16'h0000, ST_OK},
    '{OP_ALLOC,      12'd0,    16'h0002, 1'b0, 16'h0000, ST_OK},
    '{OP_COUNT,      12'd0,    16'h0000, 1'b0, 16'h0000, ST_OK},
    '{OP_ITH,        12'd0,    16'h0002, 1'b0, 16'h0000, ST_OK},
    '{OP_ITH,        12'd0,    16'h0003, 1'b1, 16'h0000, ST_NONE},
    '{OP_ITH,        12'd4095, 16'h0000, 1'b0, 16'h0000, ST_OK},
    '{OP_FREE_CHAIN, 12'd0,    16'h0000, 1'b1, 16'h0000, ST_OK},
    '{OP_READ,       12'd2,    16'h0000, 1'b0, 16'h0000, ST_OK},
    '{OP_LOAD,       12'd7,    16'h2000, 1'b1, 16'h0000, ST_OK},
    '{OP_COUNT,      12'd7,    16'h0000, 1'b1, 16'h0000, ST_CORRUPT},
    '{OP_LOAD,       12'd9,    16'h0009, 1'b1, 16'h0000, ST_OK},
    '{OP_COUNT,      12'd9,    16'h0000, 1'b1, 16'h0000, ST_CORRUPT},
    '{OP_LOAD,       12'd10,   16'h0000, 1'b1, 16'h0000, ST_OK},
    '{OP_APPEND,     12'd10,   16'd11,   1'b0, 16'h0000, ST_OK},
    '{OP_APPEND,     12'd4095, 16'd4095, 1'b0, 16'h0000, ST_OK},
    '{OP_APPEND,     12'd4095, 16'h1000, 1'b1, 16'h0000, ST_RANGE},
    '{OP_LOAD,       12'd20,   16'd21,   1'b1, 16'h0000, ST_OK},
    '{OP_LOAD,       12'd21,   16'h0000, 1'b1, 16'h0000, ST_OK},
    '{OP_FREE_CHAIN, 12'd20,   16'h0000, 1'b1, 16'h0000, ST_OK},
    '{OP_READ,       12'd21,   16'h0000, 1'b0, 16'h0000, ST_OK}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // index[11:0], value[27:12]
  logic [OP_W-1:0]       s_axis_tuser;   // opcode[2:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // result_value[15:0]
  logic [ST_W-1:0]       m_axis_tuser;   // status[1:0]

  fat16_cluster_chain_engine_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Model state: link table, active entry count and walk registers
  logic [VAL_W-1:0] link_mem [DEPTH];
  int unsigned      span;
  int unsigned      walk_at;
  int unsigned      hop_count;

  answer_t     answers_due [$];
  int unsigned mismatch_count;
  int unsigned idle_pct;
  int unsigned rx_hold;
  int unsigned filled_upto;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the engine hangs
  initial begin
    #50_000_000;
    $display("fat16_cluster_chain_engine_core verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Link table model
  // ---------------------------------------------------------------------------
  function automatic bit is_end_link(logic [VAL_W-1:0] v);
    return v >= LINK_END_LOW;
  endfunction

  function automatic bit is_stop_link(logic [VAL_W-1:0] v);
    return v == LINK_FREE || is_end_link(v);
  endfunction

  // One hop along the chain; 1 on a link outside the active range or too many hops
  function automatic bit step_link();
    logic [VAL_W-1:0] next_link;
    next_link = link_mem[walk_at];
    if (next_link >= span) return 1'b1;
    hop_count++;
    if (hop_count > span) return 1'b1;
    walk_at = next_link;
    return 1'b0;
  endfunction

  function automatic bit run_to_tail(int unsigned head);
    walk_at   = head;
    hop_count = 0;
    while (!is_stop_link(link_mem[walk_at])) begin
      if (step_link()) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Lowest free entry; returns 1 when the active range is full
  function automatic bit lowest_free(output int unsigned slot);
    slot = 0;
    for (int unsigned e = 0; e < span; e++) begin
      if (link_mem[e] == LINK_FREE) begin
        slot = e;
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit hang_cluster(int unsigned head, int unsigned fresh);
    if (run_to_tail(head)) return 1'b1;
    link_mem[walk_at] = 16'(fresh);
    link_mem[fresh]   = LINK_END;
    return 1'b0;
  endfunction

  task automatic table_answer(input opcode_e op, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] val,
                              output logic [RES_W-1:0] res, output status_e st);
    int unsigned slot;
    int unsigned k;
    int unsigned nxt;
    res = '0;
    st  = ST_OK;
    if (op != OP_FIND_FREE && idx >= span) begin
      st = ST_RANGE;
    end else begin
      case (op)
        OP_LOAD: link_mem[idx] = val;
        OP_READ: res = link_mem[idx];
        OP_FIND_FREE: begin
          if (lowest_free(slot)) st = ST_NONE;
          else res = 16'(slot);
        end
        OP_APPEND: begin
          if (val >= span) st = ST_RANGE;
          else if (hang_cluster(idx, val)) st = ST_CORRUPT;
          else res = val;
        end
        OP_ALLOC: begin
          // result keeps the last cluster linked before any stop
          for (k = 0; k < val; k++) begin
            if (lowest_free(slot)) begin
              st = ST_NONE;
              break;
            end
            if (hang_cluster(idx, slot)) begin
              st = ST_CORRUPT;
              break;
            end
            res = 16'(slot);
          end
        end
        OP_FREE_CHAIN: begin
          if (run_to_tail(idx)) begin
            st = ST_CORRUPT;
          end else begin
            walk_at = idx;
            while (!is_stop_link(link_mem[walk_at])) begin
              nxt               = link_mem[walk_at];
              link_mem[walk_at] = LINK_FREE;
              walk_at           = nxt;
            end
            // the closing entry is cleared even if already free
            link_mem[walk_at] = LINK_FREE;
          end
        end
        OP_ITH: begin
          walk_at   = idx;
          hop_count = 0;
          for (k = val; k > 0; k--) begin
            if (is_stop_link(link_mem[walk_at])) begin
              st = ST_NONE;
              break;
            end
            if (step_link()) begin
              st = ST_CORRUPT;
              break;
            end
          end
          if (st == ST_OK) res = 16'(walk_at);
        end
        default: begin
          if (run_to_tail(idx)) st = ST_CORRUPT;
          else res = 16'(hop_count) + (is_end_link(link_mem[walk_at]) ? 16'd1 : 16'd0);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string what, logic [RES_W-1:0] got, logic [RES_W-1:0] want);
    mismatch_count++;
    $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
  endtask

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (answers_due.size() == 0) begin
        note_mismatch("result with no request outstanding", m_axis_tdata, 'x);
      end else begin
        want = answers_due.pop_front();
        if (m_axis_tdata !== want.value)
          note_mismatch("result_value", m_axis_tdata, want.value);
        if (m_axis_tuser !== want.status)
          note_mismatch("status", 16'(m_axis_tuser), 16'(want.status));
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        m_axis_tready = 1'b0;
        rx_hold--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offer one request; the expected answer is queued at the transfer
  task automatic offer_request(opcode_e op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                               bit known, logic [RES_W-1:0] kres, status_e kst);
    logic [RES_W-1:0] pres;
    status_e          pst;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {4'b0, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    table_answer(op, idx, val, pres, pst);
    if (known) answers_due.push_back(answer_t'{kres, kst});
    else answers_due.push_back(answer_t'{pres, pst});
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write entries_in_use while idle, then load any newly covered entries
  task automatic set_span(int unsigned n);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = 13'(n);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    span        = (n > DEPTH) ? DEPTH : n;
    for (int unsigned e = filled_upto; e < span; e++)
      offer_request(OP_LOAD, 12'(e), LINK_FREE, 1'b1, '0, ST_OK);
    if (span > filled_upto) filled_upto = span;
  endtask

  // Random traffic: mostly chain building and walking inside the active range
  task automatic run_random(int unsigned count);
    opcode_e          op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    int unsigned      pick;
    int unsigned      r;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      r    = $urandom_range(99);
      idx  = ($urandom_range(99) < 85) ? 12'($urandom_range(span - 1))
                                       : 12'($urandom_range(4095));
      if (pick < 20) begin
        op = OP_LOAD;
        if (r < 40) val = LINK_FREE;
        else if (r < 60) val = LINK_END_LOW + 16'($urandom_range(7));
        else if (r < 85) val = 16'($urandom_range(span - 1));
        else val = 16'($urandom_range(65535));
      end else if (pick < 28) begin
        op  = OP_READ;
        val = 16'($urandom_range(65535));
      end else if (pick < 35) begin
        op  = OP_FIND_FREE;
        idx = 12'($urandom_range(4095));
        val = 16'($urandom_range(65535));
      end else if (pick < 50) begin
        op  = OP_APPEND;
        val = (r < 90) ? 16'($urandom_range(span - 1)) : 16'($urandom_range(65535));
      end else if (pick < 60) begin
        op = OP_ALLOC;
        // large counts only where the table is small enough to fill quickly
        if (r < 85) val = 16'($urandom_range(4));
        else if (span <= 64) val = 16'($urandom_range(65535));
        else val = 16'($urandom_range(20));
      end else if (pick < 70) begin
        op  = OP_FREE_CHAIN;
        val = 16'($urandom_range(65535));
      end else if (pick < 84) begin
        op  = OP_ITH;
        val = (r < 80) ? 16'($urandom_range(6)) : 16'($urandom_range(65535));
      end else begin
        op  = OP_COUNT;
        val = 16'($urandom_range(65535));
      end
      offer_request(op, idx, val, 1'b0, '0, ST_OK);
    end
  endtask

  // Main sequence
  initial begin
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    rst_ni         = 1'b0;
    idle_pct       = 21;
    rx_hold        = 0;
    span           = DEPTH;
    filled_upto    = 0;
    mismatch_count = 0;
    walk_at        = 0;
    hop_count      = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed probes at the reset setting, touching only loaded entries
    foreach (PROBES[r])
      offer_request(PROBES[r].op, PROBES[r].idx, PROBES[r].val,
                    PROBES[r].known, PROBES[r].res, PROBES[r].st);

    // Smallest table: scans and allocations run dry fast
    set_span(2);
    run_random(150);

    // Long result hold-off so the engine backs up into the input
    set_span(16);
    run_random(100);
    rx_hold = 300;
    run_random(150);
    drain();
    run_random(150);

    // Stretch with no stalls on either side
    idle_pct = 0;
    set_span(64);
    run_random(400);
    drain();
    idle_pct = 21;

    // Larger table
    set_span(256);
    run_random(250);

    set_span(3);
    run_random(200);
    set_span(200);
    run_random(350);

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("fat16_cluster_chain_engine_core verification clean");
    end else begin
      $display("fat16_cluster_chain_engine_core verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/fcc_pkg.sv
rtl/fcc_ctrl.sv
rtl/fcc_dpath.sv
rtl/fat16_cluster_chain_engine_core.sv
dv/fat16_cluster_chain_engine_core_tb.sv
